### sv/jsu_pkg.sv
// Shared types and codes for the JSON string decoder
package jsu_pkg;

   // Scan phase of the decoder
   typedef enum logic [3:0] {
      PH_IDLE   = 4'd0,
      PH_SPACE  = 4'd1,
      PH_STR    = 4'd2,
      PH_ESC    = 4'd3,
      PH_HEX_HI = 4'd4,
      PH_BSL_LO = 4'd5,
      PH_U_LO   = 4'd6,
      PH_HEX_LO = 4'd7
   } phase_type;

   // Result kinds
   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_CLOSE = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // Up to four results caused by one input item, lowest byte goes out first
   typedef struct packed {
      logic [2:0]      count;
      logic [1:0]      kind;
      logic [3:0][7:0] bytes;
   } result_type;

endpackage

### sv/jsu_decode.sv
// Byte decoder: scan state plus the logic that turns one text byte into results
module jsu_decode
   import jsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] in_byte,
   input  logic       start_scan,
   input  logic       end_of_text,
   output result_type result
);

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_N     = 8'h6E;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_U     = 8'h75;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] WS_LOW   = 8'h09;
   localparam logic [7:0] WS_HIGH  = 8'h0D;

   localparam logic [20:0] CP_ONE   = 21'h00007F;
   localparam logic [20:0] CP_TWO   = 21'h0007FF;
   localparam logic [20:0] CP_THREE = 21'h00FFFF;
   localparam logic [20:0] CP_PLANE = 21'h010000;

   // top six bits of a high and of a low surrogate
   localparam logic [5:0] SUR_HIGH = 6'b110110;
   localparam logic [5:0] SUR_LOW  = 6'b110111;

   phase_type   phase_ff, phase_in;
   logic [15:0] high_ff, high_in;
   logic [15:0] low_ff, low_in;
   logic [1:0]  dcnt_ff, dcnt_in;

   phase_type   ph;
   logic [15:0] hi_cur;
   logic [15:0] lo_cur;
   logic [1:0]  dc_cur;
   logic [4:0]  hexv;
   logic        err;
   logic        closed;
   logic [20:0] pair_cp;

   // hex digit value, bit 4 set when the byte is no digit
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      v = 5'h10;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = {1'b0, c[3:0]};
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         v = {1'b0, c[3:0] + 4'd9};
      end
      return v;
   endfunction

   // UTF-8 form of a code point
   function automatic result_type utf8_encode(input logic [20:0] cp);
      result_type r;
      r = '0;
      r.kind = KIND_BYTE;
      if (cp <= CP_ONE) begin
         r.count    = 3'd1;
         r.bytes[0] = cp[7:0];
      end else if (cp <= CP_TWO) begin
         r.count    = 3'd2;
         r.bytes[0] = {3'b110, cp[10:6]};
         r.bytes[1] = {2'b10, cp[5:0]};
      end else if (cp <= CP_THREE) begin
         r.count    = 3'd3;
         r.bytes[0] = {4'b1110, cp[15:12]};
         r.bytes[1] = {2'b10, cp[11:6]};
         r.bytes[2] = {2'b10, cp[5:0]};
      end else begin
         r.count    = 3'd4;
         r.bytes[0] = {5'b11110, cp[20:18]};
         r.bytes[1] = {2'b10, cp[17:12]};
         r.bytes[2] = {2'b10, cp[11:6]};
         r.bytes[3] = {2'b10, cp[5:0]};
      end
      return r;
   endfunction

   // single result of a given kind and byte
   function automatic result_type single(input logic [7:0] b, input logic [1:0] k);
      result_type r;
      r = '0;
      r.count    = 3'd1;
      r.kind     = k;
      r.bytes[0] = b;
      return r;
   endfunction

   // next state and results for the byte on offer
   always_comb begin
      ph       = start_scan ? PH_SPACE : phase_ff;
      hi_cur   = start_scan ? 16'h0000 : high_ff;
      lo_cur   = start_scan ? 16'h0000 : low_ff;
      dc_cur   = start_scan ? 2'd0 : dcnt_ff;
      hexv     = hex_value(in_byte);
      err      = 1'b0;
      closed   = 1'b0;
      result   = '0;
      phase_in = ph;
      high_in  = hi_cur;
      low_in   = lo_cur;
      dcnt_in  = dc_cur;
      pair_cp  = '0;

      case (ph)
         PH_SPACE: begin
            if (in_byte == CH_QUOTE) begin
               phase_in = PH_STR;
            end else if (!((in_byte >= WS_LOW && in_byte <= WS_HIGH) ||
                           in_byte == CH_SPACE)) begin
               err = 1'b1;
            end
         end
         PH_STR: begin
            if (in_byte == CH_QUOTE) begin
               closed = 1'b1;
            end else if (in_byte < CH_SPACE) begin
               err = 1'b1;
            end else if (in_byte == CH_BSL) begin
               phase_in = PH_ESC;
            end else begin
               result = single(in_byte, KIND_BYTE);
            end
         end
         PH_ESC: begin
            phase_in = PH_STR;
            case (in_byte)
               CH_QUOTE, CH_BSL, CH_SLASH: result = single(in_byte, KIND_BYTE);
               CH_B: result = single(8'h08, KIND_BYTE);
               CH_F: result = single(8'h0C, KIND_BYTE);
               CH_N: result = single(8'h0A, KIND_BYTE);
               CH_R: result = single(8'h0D, KIND_BYTE);
               CH_T: result = single(8'h09, KIND_BYTE);
               CH_U: begin
                  phase_in = PH_HEX_HI;
                  high_in  = 16'h0000;
                  dcnt_in  = 2'd0;
               end
               default: err = 1'b1;
            endcase
         end
         PH_HEX_HI: begin
            if (hexv[4]) begin
               err = 1'b1;
            end else begin
               high_in = {hi_cur[11:0], hexv[3:0]};
               if (dc_cur != 2'd3) begin
                  dcnt_in = dc_cur + 2'd1;
               end else begin
                  dcnt_in = 2'd0;
                  if (high_in[15:10] == SUR_HIGH) begin
                     phase_in = PH_BSL_LO;
                  end else if (high_in[15:10] == SUR_LOW) begin
                     err = 1'b1;
                  end else begin
                     result   = utf8_encode({5'b00000, high_in});
                     phase_in = PH_STR;
                  end
               end
            end
         end
         PH_BSL_LO: begin
            if (in_byte == CH_BSL) begin
               phase_in = PH_U_LO;
            end else begin
               err = 1'b1;
            end
         end
         PH_U_LO: begin
            if (in_byte == CH_U) begin
               phase_in = PH_HEX_LO;
               low_in   = 16'h0000;
               dcnt_in  = 2'd0;
            end else begin
               err = 1'b1;
            end
         end
         PH_HEX_LO: begin
            if (hexv[4]) begin
               err = 1'b1;
            end else begin
               low_in = {lo_cur[11:0], hexv[3:0]};
               if (dc_cur != 2'd3) begin
                  dcnt_in = dc_cur + 2'd1;
               end else begin
                  dcnt_in = 2'd0;
                  if (low_in[15:10] != SUR_LOW) begin
                     err = 1'b1;
                  end else begin
                     pair_cp  = {1'b0, hi_cur[9:0], low_in[9:0]} + CP_PLANE;
                     result   = utf8_encode(pair_cp);
                     phase_in = PH_STR;
                  end
               end
            end
         end
         default: phase_in = PH_IDLE;
      endcase

      // error, close and end of text inside an unfinished scan replace whatever the byte decoded
      if (err) begin
         result   = single(8'h00, KIND_ERROR);
         phase_in = PH_IDLE;
      end else if (closed) begin
         result   = single(8'h00, KIND_CLOSE);
         phase_in = PH_IDLE;
      end else if (end_of_text && phase_in != PH_IDLE) begin
         result   = single(8'h00, KIND_ERROR);
         phase_in = PH_IDLE;
      end
   end

   // scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         high_ff  <= 16'h0000;
         low_ff   <= 16'h0000;
         dcnt_ff  <= 2'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         high_ff  <= high_in;
         low_ff   <= low_in;
         dcnt_ff  <= dcnt_in;
      end
   end

endmodule

### sv/jsu_outbuf.sv
// Result register: holds the results of one item and hands them out in order
module jsu_outbuf
   import jsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type result,
   output logic       can_load,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic [1:0] rsp_tuser,
   output logic       rsp_tlast
);

   logic [2:0]      cnt_ff, cnt_in;
   logic [1:0]      kind_ff, kind_in;
   logic [3:0][7:0] bytes_ff, bytes_in;
   logic            fire;

   // a new item may enter once at most the last result is on its way out
   assign can_load = (cnt_ff == 3'd0) || (cnt_ff == 3'd1 && rsp_tready);

   // drain by shifting down, reload when an item brings results
   always_comb begin
      fire     = (cnt_ff != 3'd0) && rsp_tready;
      cnt_in   = cnt_ff;
      kind_in  = kind_ff;
      bytes_in = bytes_ff;
      if (fire) begin
         cnt_in   = cnt_ff - 3'd1;
         bytes_in = {8'h00, bytes_ff[3:1]};
      end
      if (load && result.count != 3'd0) begin
         cnt_in   = result.count;
         kind_in  = result.kind;
         bytes_in = result.bytes;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 3'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      bytes_ff <= bytes_in;
   end

   assign rsp_tvalid = (cnt_ff != 3'd0);
   assign rsp_tdata  = bytes_ff[0];
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = (cnt_ff == 3'd1);

endmodule

### sv/json_string_unescape.sv
// Channel  Dir  tdata        tuser            tlast
// req      in   in_byte[7:0] start_scan       end_of_text
// rsp      out  out_byte[7:0] kind[1:0]       run_last
//
// One byte is taken per cycle while the result register can load. A byte that
// decodes to several results holds the input while the result register drains.
// Decoding is one combinational pass from the port into the result register.
// Reset (synchronous) returns the scan to idle and empties the result register.
// rsp_tready low holds the results; req_tready follows it combinationally.
module json_string_unescape
   import jsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tuser,   // [0] start_scan
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [1:0] rsp_tuser,   // [1:0] kind
   output logic       rsp_tlast
);

   result_type result;
   logic       accept;
   logic       can_load;

   assign req_tready = can_load;
   assign accept     = req_tvalid & can_load;

   // byte decoder and scan state
   jsu_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .in_byte     (req_tdata),
      .start_scan  (req_tuser),
      .end_of_text (req_tlast),
      .result      (result)
   );

   // result register and serialiser
   jsu_outbuf u_outbuf (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .result     (result),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
